### hw/rtl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared widths, character codes, result kinds, register indexes and the
// command/status bundles between the console controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tccs_pkg;

    // Field widths
    localparam int COL_W     = 8;   // column coordinate
    localparam int ROW_W     = 7;   // row coordinate
    localparam int CHAR_W    = 8;   // stored character
    localparam int KIND_W    = 2;   // result kind
    localparam int CUR_COL_W = 9;   // cursor column, may sit one past the last column

    // Parameter defaults
    localparam int MAX_COLUMNS_DEF = 240;
    localparam int MAX_LINES_DEF   = 80;
    localparam int TAB_STOP_DEF    = 8;

    // Result count cap per input transaction
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = KIND_W;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

    // Operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // Configuration registers
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 2'd2;

    localparam logic [COL_W-1:0] GRID_COLS_RST = 8'd80;
    localparam logic [ROW_W-1:0] GRID_ROWS_RST = 7'd50;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;     // blank one store entry of the reset sweep
        logic load_item;    // capture the input transaction
        logic rd_cell;      // read the requested cell
        logic put_setup;    // load the put count
        logic home_col;     // carriage return
        logic next_line;    // home column, move down one row
        logic put_write;    // store one character and report it
        logic scr_copy;     // read one cell of the row shift
        logic scr_blank;    // blank one cell of the bottom row
        logic scr_emit;     // report the scroll
        logic rd_emit;      // report the read data
        logic finish;       // close the transaction
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic op_read;
        logic enable;
        logic is_cr;
        logic is_lf;
        logic is_tab;
        logic col_wrap;
        logic row_at_bottom;
        logic rows_one;
        logic tab_last;
        logic scr_col_last;
        logic scr_row_last;
        logic emit_ready;
        logic fin_ready;
    } stat_t;

endpackage

`default_nettype wire

### hw/rtl/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console core: keeps a cursor and a character grid, prints bytes,
// expands tabs, wraps, scrolls and serves cell reads.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                          | tuser  | tlast
//  ---------+-----+---------------------------------------------+--------+------------
//  s_*      | in  | char_code[7:0] read_row[14:8] read_col[22:15] | op     | -
//  m_*      | out | cell_row[6:0] cell_col[14:7] cell_char[22:15]  | kind   | last_of_run
//           |     | out_of_range[23]                             |        |
//  cfg_*    | in  | cfg_index selects enable / grid_cols / grid_rows, written on cfg_we
//
//  A scroll shifts the rows up (no shift on a one-row grid), blanks the bottom
//  row and reports it: the row shift goes through the single store write port
//  one cell per cycle.
//  After reset the store is blanked with s_tready low; configuration writes are taken meanwhile.
//  A stalled m_tready holds the block once two results are waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll #(
    parameter int MAX_COLUMNS = tccs_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_LINES   = tccs_pkg::MAX_LINES_DEF,
    parameter int TAB_STOP    = tccs_pkg::TAB_STOP_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [tccs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [tccs_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tccs_pkg::S_TDATA_W-1:0]    s_tdata,  // char_code, read_row, read_col
    input  wire logic [tccs_pkg::S_TUSER_W-1:0]    s_tuser,  // op
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tccs_pkg::M_TDATA_W-1:0]         m_tdata,  // cell_row, cell_col, cell_char,
                                                             // out_of_range
    output logic [tccs_pkg::M_TUSER_W-1:0]         m_tuser,  // kind
    output logic                                   m_tlast
);

    tccs_pkg::cmd_t  cmd;
    tccs_pkg::stat_t stat;

    logic [tccs_pkg::ROW_W-1:0]  out_row;
    logic [tccs_pkg::COL_W-1:0]  out_col;
    logic [tccs_pkg::CHAR_W-1:0] out_char;
    logic                        out_oor;

    tccs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tccs_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_LINES   (MAX_LINES),
        .TAB_STOP    (TAB_STOP)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_tuser[0]),
        .in_char   (s_tdata[7:0]),
        .in_row    (s_tdata[14:8]),
        .in_col    (s_tdata[22:15]),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (m_tuser),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_char  (out_char),
        .out_oor   (out_oor),
        .out_last  (m_tlast)
    );

    assign m_tdata = {out_oor, out_char, out_col, out_row};

endmodule

`default_nettype wire

### hw/rtl/tccs_ctrl.sv
// ----------------------------------------------------------------------------
// tccs_ctrl
// Sequencer of the console: reset sweep, dispatch of each transaction,
// character puts, row shift for scrolling and result closing.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire tccs_pkg::stat_t stat,
    output tccs_pkg::cmd_t      cmd
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_DISPATCH  = 4'd2;
    localparam logic [3:0] S_RD_EMIT   = 4'd3;
    localparam logic [3:0] S_PUT       = 4'd4;
    localparam logic [3:0] S_SCR_COPY  = 4'd5;
    localparam logic [3:0] S_SCR_DRAIN = 4'd6;
    localparam logic [3:0] S_SCR_BLANK = 4'd7;
    localparam logic [3:0] S_SCR_EMIT  = 4'd8;
    localparam logic [3:0] S_FINISH    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       ret_put_reg;
    logic       ret_put_next;

    always_comb
    begin
        cmd          = '0;
        in_ready     = 1'b0;
        state_next   = state_reg;
        ret_put_next = ret_put_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.op_read)
                begin
                    cmd.rd_cell = 1'b1;
                    state_next  = S_RD_EMIT;
                end
                else if (!stat.enable)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.is_cr)
                begin
                    cmd.home_col = 1'b1;
                    state_next   = S_FINISH;
                end
                else if (stat.is_lf)
                begin
                    cmd.next_line = 1'b1;
                    if (stat.row_at_bottom)
                    begin
                        ret_put_next = 1'b0;
                        state_next   = stat.rows_one ? S_SCR_BLANK : S_SCR_COPY;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    cmd.put_setup = 1'b1;
                    state_next    = S_PUT;
                end
            end
            S_RD_EMIT:
            begin
                if (stat.emit_ready)
                begin
                    cmd.rd_emit = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_PUT:
            begin
                if (stat.col_wrap)
                begin
                    // wrap first; scroll when already on the bottom row
                    cmd.next_line = 1'b1;
                    if (stat.row_at_bottom)
                    begin
                        ret_put_next = 1'b1;
                        state_next   = stat.rows_one ? S_SCR_BLANK : S_SCR_COPY;
                    end
                end
                else if (stat.emit_ready)
                begin
                    cmd.put_write = 1'b1;
                    if (stat.tab_last)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCR_COPY:
            begin
                cmd.scr_copy = 1'b1;
                if (stat.scr_col_last && stat.scr_row_last)
                begin
                    state_next = S_SCR_DRAIN;
                end
            end
            S_SCR_DRAIN:
            begin
                // last copied cell is written back here
                state_next = S_SCR_BLANK;
            end
            S_SCR_BLANK:
            begin
                cmd.scr_blank = 1'b1;
                if (stat.scr_col_last)
                begin
                    state_next = S_SCR_EMIT;
                end
            end
            S_SCR_EMIT:
            begin
                if (stat.emit_ready)
                begin
                    cmd.scr_emit = 1'b1;
                    state_next   = ret_put_reg ? S_PUT : S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.fin_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            ret_put_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_put_reg <= ret_put_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tccs_dp.sv
// ----------------------------------------------------------------------------
// tccs_dp
// Console datapath: configuration registers, cursor, character store,
// row-shift counters and the two-deep result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_dp #(
    parameter int MAX_COLUMNS = tccs_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_LINES   = tccs_pkg::MAX_LINES_DEF,
    parameter int TAB_STOP    = tccs_pkg::TAB_STOP_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [tccs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tccs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_op,
    input  wire logic [tccs_pkg::CHAR_W-1:0]        in_char,
    input  wire logic [tccs_pkg::ROW_W-1:0]         in_row,
    input  wire logic [tccs_pkg::COL_W-1:0]         in_col,
    input  wire tccs_pkg::cmd_t                     cmd,
    output tccs_pkg::stat_t                         stat,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic [tccs_pkg::KIND_W-1:0]             out_kind,
    output logic [tccs_pkg::ROW_W-1:0]              out_row,
    output logic [tccs_pkg::COL_W-1:0]              out_col,
    output logic [tccs_pkg::CHAR_W-1:0]             out_char,
    output logic                                    out_oor,
    output logic                                    out_last
);

    localparam int COL_W     = tccs_pkg::COL_W;
    localparam int ROW_W     = tccs_pkg::ROW_W;
    localparam int CHAR_W    = tccs_pkg::CHAR_W;
    localparam int KIND_W    = tccs_pkg::KIND_W;
    localparam int CUR_COL_W = tccs_pkg::CUR_COL_W;
    localparam int RES_CNT_W = tccs_pkg::RES_CNT_W;
    localparam int ROW_AW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int ADDR_W    = ROW_AW + COL_W;
    localparam int DEPTH     = MAX_LINES * (2 ** COL_W);
    localparam int PH_W      = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int TCNT_W    = $clog2(TAB_STOP + 1);

    // Configuration
    logic              enable_reg;
    logic [COL_W-1:0]  grid_cols_reg;
    logic [ROW_W-1:0]  grid_rows_reg;
    logic [COL_W-1:0]  cols_m1;
    logic [ROW_W-1:0]  rows_m1;

    // Transaction
    logic              item_op_reg;
    logic [CHAR_W-1:0] item_char_reg;
    logic [ROW_W-1:0]  item_row_reg;
    logic [COL_W-1:0]  item_col_reg;
    logic              read_oor;
    logic [CHAR_W-1:0] put_char;

    // Cursor and counters
    logic [CUR_COL_W-1:0] cursor_col_reg;
    logic [ROW_W-1:0]     cursor_row_reg;
    logic [PH_W-1:0]      phase_reg;
    logic [TCNT_W-1:0]    tab_cnt_reg;
    logic [ROW_W-1:0]     scr_row_reg;
    logic [COL_W-1:0]     scr_col_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [ROW_W-1:0]     row_eff;
    logic [PH_W-1:0]      phase_inc;

    // Store
    logic [CHAR_W-1:0] mem [0:DEPTH-1];
    logic [CHAR_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              cp_valid_reg;
    logic [ADDR_W-1:0] cp_dst_reg;

    // Results
    logic [RES_CNT_W-1:0] res_cnt_reg;
    logic                 capped;
    logic                 emit;
    logic                 emit_take;
    logic                 push;
    logic                 out_free;
    logic                 pend_valid_reg;
    logic [KIND_W-1:0]    pend_kind_reg;
    logic [ROW_W-1:0]     pend_row_reg;
    logic [COL_W-1:0]     pend_col_reg;
    logic [CHAR_W-1:0]    pend_char_reg;
    logic                 pend_oor_reg;
    logic [KIND_W-1:0]    new_kind;
    logic [ROW_W-1:0]     new_row;
    logic [COL_W-1:0]     new_col;
    logic [CHAR_W-1:0]    new_char;
    logic                 new_oor;
    logic                 out_valid_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [COL_W-1:0]     out_col_reg;
    logic [CHAR_W-1:0]    out_char_reg;
    logic                 out_oor_reg;
    logic                 out_last_reg;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            grid_cols_reg <= tccs_pkg::GRID_COLS_RST;
            grid_rows_reg <= tccs_pkg::GRID_ROWS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tccs_pkg::REG_ENABLE:    enable_reg    <= cfg_data[0];
                tccs_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_data[COL_W-1:0];
                tccs_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_data[ROW_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Saturate the grid size to 1..MAX, kept as size minus one
    always_comb
    begin
        if (grid_cols_reg == '0)
        begin
            cols_m1 = '0;
        end
        else if ({1'b0, grid_cols_reg} > CUR_COL_W'(MAX_COLUMNS))
        begin
            cols_m1 = COL_W'(MAX_COLUMNS - 1);
        end
        else
        begin
            cols_m1 = grid_cols_reg - 1'b1;
        end

        if (grid_rows_reg == '0)
        begin
            rows_m1 = '0;
        end
        else if ({1'b0, grid_rows_reg} > (ROW_W + 1)'(MAX_LINES))
        begin
            rows_m1 = ROW_W'(MAX_LINES - 1);
        end
        else
        begin
            rows_m1 = grid_rows_reg - 1'b1;
        end
    end

    // ------------------------------------------------------------ transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_op_reg   <= in_op;
            item_char_reg <= in_char;
            item_row_reg  <= in_row;
            item_col_reg  <= in_col;
        end
    end

    assign read_oor = (item_row_reg > rows_m1) || (item_col_reg > cols_m1);
    assign put_char = (item_char_reg == tccs_pkg::CH_TAB) ? tccs_pkg::CH_BLANK
                                                          : item_char_reg;

    // ----------------------------------------------------------------- cursor
    assign row_eff   = (cursor_row_reg > rows_m1) ? rows_m1 : cursor_row_reg;
    assign phase_inc = (phase_reg == PH_W'(TAB_STOP - 1)) ? '0 : phase_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            phase_reg      <= '0;
            tab_cnt_reg    <= '0;
            scr_row_reg    <= '0;
            scr_col_reg    <= '0;
            clr_addr_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end

            if (cmd.home_col)
            begin
                cursor_col_reg <= '0;
                phase_reg      <= '0;
            end

            if (cmd.next_line)
            begin
                cursor_col_reg <= '0;
                phase_reg      <= '0;
                scr_row_reg    <= ROW_W'(1);
                scr_col_reg    <= '0;
                if (cursor_row_reg < rows_m1)
                begin
                    cursor_row_reg <= cursor_row_reg + 1'b1;
                end
            end

            if (cmd.put_setup)
            begin
                if (item_char_reg == tccs_pkg::CH_TAB)
                begin
                    tab_cnt_reg <= TCNT_W'(TAB_STOP) - TCNT_W'(phase_reg);
                end
                else
                begin
                    tab_cnt_reg <= TCNT_W'(1);
                end
            end

            if (cmd.put_write)
            begin
                cursor_row_reg <= row_eff;
                cursor_col_reg <= cursor_col_reg + 1'b1;
                phase_reg      <= phase_inc;
                tab_cnt_reg    <= tab_cnt_reg - 1'b1;
            end

            if (cmd.scr_copy)
            begin
                if (scr_col_reg == cols_m1)
                begin
                    scr_col_reg <= '0;
                    scr_row_reg <= scr_row_reg + 1'b1;
                end
                else
                begin
                    scr_col_reg <= scr_col_reg + 1'b1;
                end
            end

            if (cmd.scr_blank)
            begin
                scr_col_reg <= (scr_col_reg == cols_m1) ? '0 : scr_col_reg + 1'b1;
            end

            if (cmd.scr_emit)
            begin
                cursor_row_reg <= rows_m1;
            end
        end
    end

    // ------------------------------------------------------------------ store
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = {item_row_reg[ROW_AW-1:0], item_col_reg};
        if (cmd.rd_cell)
        begin
            rd_en = !read_oor;
        end
        else if (cmd.scr_copy)
        begin
            rd_en   = 1'b1;
            rd_addr = {scr_row_reg[ROW_AW-1:0], scr_col_reg};
        end
    end

    // Copy write follows its read in the next cycle and takes the port first
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cp_dst_reg;
        wr_data = rd_data_reg;
        if (cp_valid_reg)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = tccs_pkg::CH_BLANK;
        end
        else if (cmd.put_write)
        begin
            wr_en   = 1'b1;
            wr_addr = {row_eff[ROW_AW-1:0], cursor_col_reg[COL_W-1:0]};
            wr_data = put_char;
        end
        else if (cmd.scr_blank)
        begin
            wr_en   = 1'b1;
            wr_addr = {rows_m1[ROW_AW-1:0], scr_col_reg};
            wr_data = tccs_pkg::CH_BLANK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_valid_reg <= 1'b0;
        end
        else
        begin
            cp_valid_reg <= cmd.scr_copy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scr_copy)
        begin
            cp_dst_reg <= {ROW_AW'(scr_row_reg - 1'b1), scr_col_reg};
        end
    end

    // ---------------------------------------------------------------- results
    assign capped    = (res_cnt_reg == RES_CNT_W'(tccs_pkg::MAX_RESULTS));
    assign emit      = cmd.put_write || cmd.scr_emit || cmd.rd_emit;
    assign emit_take = emit && !capped;
    assign out_free  = !out_valid_reg || out_ready;
    // pending result moves on once the next one exists or the transaction ends
    assign push      = pend_valid_reg && (emit_take || cmd.finish);

    always_comb
    begin
        new_kind = tccs_pkg::KIND_WRITE;
        new_row  = row_eff;
        new_col  = cursor_col_reg[COL_W-1:0];
        new_char = put_char;
        new_oor  = 1'b0;
        if (cmd.scr_emit)
        begin
            new_kind = tccs_pkg::KIND_SCROLL;
            new_row  = rows_m1;
            new_col  = '0;
            new_char = tccs_pkg::CH_BLANK;
        end
        else if (cmd.rd_emit)
        begin
            new_kind = tccs_pkg::KIND_READ;
            new_row  = item_row_reg;
            new_col  = item_col_reg;
            new_char = read_oor ? '0 : rd_data_reg;
            new_oor  = read_oor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                res_cnt_reg    <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (emit_take)
            begin
                res_cnt_reg    <= res_cnt_reg + 1'b1;
                pend_valid_reg <= 1'b1;
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_take)
        begin
            pend_kind_reg <= new_kind;
            pend_row_reg  <= new_row;
            pend_col_reg  <= new_col;
            pend_char_reg <= new_char;
            pend_oor_reg  <= new_oor;
        end
        if (push)
        begin
            out_kind_reg <= pend_kind_reg;
            out_row_reg  <= pend_row_reg;
            out_col_reg  <= pend_col_reg;
            out_char_reg <= pend_char_reg;
            out_oor_reg  <= pend_oor_reg;
            out_last_reg <= cmd.finish;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_char  = out_char_reg;
    assign out_oor   = out_oor_reg;
    assign out_last  = out_last_reg;

    // ----------------------------------------------------------------- status
    always_comb
    begin
        stat               = '0;
        stat.clr_last      = (clr_addr_reg == ADDR_W'(DEPTH - 1));
        stat.op_read       = (item_op_reg == tccs_pkg::OP_READ);
        stat.enable        = enable_reg;
        stat.is_cr         = (item_char_reg == tccs_pkg::CH_CR);
        stat.is_lf         = (item_char_reg == tccs_pkg::CH_LF);
        stat.is_tab        = (item_char_reg == tccs_pkg::CH_TAB);
        stat.col_wrap      = (cursor_col_reg > {1'b0, cols_m1});
        stat.row_at_bottom = (cursor_row_reg >= rows_m1);
        stat.rows_one      = (rows_m1 == '0);
        stat.tab_last      = (tab_cnt_reg == TCNT_W'(1));
        stat.scr_col_last  = (scr_col_reg == cols_m1);
        stat.scr_row_last  = (scr_row_reg == rows_m1);
        stat.emit_ready    = capped || !pend_valid_reg || out_free;
        stat.fin_ready     = !pend_valid_reg || out_free;
    end

    // ------------------------------------------------------------- assertions
    a_res_cap: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= RES_CNT_W'(tccs_pkg::MAX_RESULTS))
        else $error("result count above cap");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed onto a full output register");

    a_wr_port: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid_reg |-> !(cmd.clr_step || cmd.put_write || cmd.scr_blank))
        else $error("store write port collision");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cursor_row_reg} < (ROW_W + 1)'(MAX_LINES))
        else $error("cursor row past the store");

endmodule

`default_nettype wire
